>>> rtl/nmea_sentence_checker_assert.svh
// ----------------------------------------------------------------------------
// nmea sentence checker assertion macros
// shared concurrent assertion forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_ASSERT_SVH

// property must hold at every edge out of reset
`define NSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define NSC_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// types, character codes and helpers for the nmea sentence checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);
  localparam int PREFIX_LEN    = 6;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TYPE_NONE = 2'd0,
    TYPE_RMC  = 2'd1,
    TYPE_GGA  = 2'd2
  } stype_e;

  typedef struct packed {
    status_e     status;
    stype_e      stype;
    logic [7:0]  computed;
    logic [7:0]  received;
    logic [6:0]  line_length;
  } line_result_t;

  // expected prefix character, "$GPRMC" or "$GPGGA"
  function automatic logic [7:0] prefix_char(input logic gga, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = gga ? 8'h47 : 8'h52;
      3'd4:    ch = gga ? 8'h47 : 8'h4D;
      3'd5:    ch = gga ? 8'h41 : 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // {is hex digit, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/nsc_byte_if.sv
// ----------------------------------------------------------------------------
// nsc_byte_if
// valid/ready channel carrying one received serial byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/nsc_result_if.sv
// ----------------------------------------------------------------------------
// nsc_result_if
// valid/ready channel carrying one sentence check result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] sentence_type;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;
  logic [6:0] line_length;

  modport source (
    output valid, output status, output sentence_type,
    output computed_checksum, output received_checksum, output line_length,
    input ready
  );
  modport sink (
    input valid, input status, input sentence_type,
    input computed_checksum, input received_checksum, input line_length,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// nmea 0183 rmc/gga sentence checksum checker over a byte stream
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the output channel does not stall and
// gives at most one result per byte, so without back-pressure it runs at a
// sustained one byte per clock. A byte passes through an input register, a
// single pass of line-state logic and a result register, which drives the result
// of the byte that caused it (the line end, or the byte that overflows a
// 127-character line) on the output channel. A stalled output holds the pipe;
// while a finished result waits, the input register still takes one byte and
// then holds it, and the line state only moves when the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checker
  import nsc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  nsc_byte_if.sink       byte_i,
  nsc_result_if.source   result_o
);

  logic         advance;
  logic         step;
  logic [7:0]   cur_byte;
  logic         res_valid;
  line_result_t res;

  nsc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .step_o    (step),
    .byte_o    (cur_byte)
  );

  nsc_line_state u_line_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (cur_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nsc_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && res_valid),
    .res_i     (res),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

>>> rtl/nsc_in_stage.sv
// ----------------------------------------------------------------------------
// nsc_in_stage
// input register for received bytes, refilled while the pipe advances
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsc_in_stage
  import nsc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nsc_byte_if.sink    byte_i,
  input  wire logic   advance_i,
  output logic        step_o,
  output logic [7:0]  byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign byte_i.ready = !valid_q || advance_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign step_o       = valid_q && advance_i;
  assign byte_o       = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nsc_line_state.sv
// ----------------------------------------------------------------------------
// nsc_line_state
// per-line state: prefix match, xor, star tracking, tail characters, nul truncation, count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nmea_sentence_checker_assert.svh"

module nsc_line_state
  import nsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output logic             res_valid_o,
  output line_result_t     res_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       flags_q, flags_d;
  logic [7:0]       xor_q, xor_d;
  logic             star_q, star_d;
  logic [15:0]      tail_q, tail_d;
  logic [1:0]       sblt_q, sblt_d;
  logic             trunc_q, trunc_d;

  logic             is_eol, is_full, is_star, in_prefix;
  logic [7:0]       tail_hi, tail_lo;
  logic [4:0]       hex_hi, hex_lo;
  logic [7:0]       received;

  assign is_eol    = (byte_i == CHAR_CR) || (byte_i == CHAR_LF);
  assign is_full   = (count_q == CNT_W'(LINE_CAPACITY - 1));
  assign is_star   = (byte_i == CHAR_STAR);
  assign in_prefix = (count_q < CNT_W'(PREFIX_LEN));
  assign tail_hi   = tail_q[15:8];
  assign tail_lo   = tail_q[7:0];
  assign hex_hi    = hex_digit(tail_hi);
  assign hex_lo    = hex_digit(tail_lo);

  // received checksum, parsed strtol style
  always_comb begin
    received = 8'h00;
    if (sblt_q[1] && (tail_hi != CHAR_STAR) && hex_hi[4]) begin
      received = hex_lo[4] ? {hex_hi[3:0], hex_lo[3:0]} : {4'h0, hex_hi[3:0]};
    end
  end

  // next line state
  always_comb begin
    count_d = count_q;
    flags_d = flags_q;
    xor_d   = xor_q;
    star_d  = star_q;
    tail_d  = tail_q;
    sblt_d  = sblt_q;
    trunc_d = trunc_q;
    if (is_eol || is_full) begin
      count_d = '0;
      flags_d = 2'b11;
      xor_d   = 8'h00;
      star_d  = 1'b0;
      tail_d  = 16'h0000;
      sblt_d  = 2'b00;
      trunc_d = 1'b0;
    end else begin
      count_d = count_q + CNT_W'(1);
      if (!trunc_q) begin
        if (byte_i == CHAR_NUL) begin
          trunc_d = 1'b1;
          if (in_prefix) begin
            flags_d = 2'b00;
          end
        end else begin
          if (in_prefix) begin
            if (byte_i != prefix_char(1'b0, count_q[2:0])) begin
              flags_d[0] = 1'b0;
            end
            if (byte_i != prefix_char(1'b1, count_q[2:0])) begin
              flags_d[1] = 1'b0;
            end
          end
          tail_d = {tail_q[7:0], byte_i};
          if (count_q != '0) begin
            sblt_d = {sblt_q[0], star_q};
            if (is_star) begin
              star_d = 1'b1;
            end else if (!star_q) begin
              xor_d = xor_q ^ byte_i;
            end
          end else begin
            sblt_d = {sblt_q[0], 1'b0};
          end
        end
      end
    end
  end

  // result of this byte
  always_comb begin
    res_valid_o       = 1'b0;
    res_o.status      = ST_OK;
    res_o.stype       = TYPE_NONE;
    res_o.computed    = 8'h00;
    res_o.received    = 8'h00;
    res_o.line_length = 7'(count_q);
    if (is_eol) begin
      res_valid_o    = !in_prefix && (flags_q != 2'b00);
      res_o.status   = (xor_q == received) ? ST_OK : ST_MISMATCH;
      res_o.stype    = flags_q[0] ? TYPE_RMC : TYPE_GGA;
      res_o.computed = xor_q;
      res_o.received = received;
    end else if (is_full) begin
      res_valid_o  = 1'b1;
      res_o.status = ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flags_q <= 2'b11;
      xor_q   <= 8'h00;
      star_q  <= 1'b0;
      tail_q  <= 16'h0000;
      sblt_q  <= 2'b00;
      trunc_q <= 1'b0;
    end else if (step_i) begin
      count_q <= count_d;
      flags_q <= flags_d;
      xor_q   <= xor_d;
      star_q  <= star_d;
      tail_q  <= tail_d;
      sblt_q  <= sblt_d;
      trunc_q <= trunc_d;
    end
  end

  `NSC_ASSERT(a_eol_clears, (step_i && is_eol) |=> (count_q == '0 && !star_q), "line end must clear line")
  `NSC_ASSERT_NEVER(a_star_early, star_q && (count_q < CNT_W'(2)), "star seen before second char")
  `NSC_ASSERT_NEVER(a_trunc_prefix, trunc_q && in_prefix && (flags_q != 2'b00), "short truncated line still matches")
  `NSC_ASSERT(a_full_result, (step_i && is_full && !is_eol) |-> res_valid_o, "overflow gave no result")

endmodule

`default_nettype wire

>>> rtl/nsc_out_stage.sv
// ----------------------------------------------------------------------------
// nsc_out_stage
// result register driving the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsc_out_stage
  import nsc_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire line_result_t  res_i,
  output logic               advance_o,
  nsc_result_if.source       result_o
);

  logic         valid_q, valid_d;
  line_result_t res_q;

  assign advance_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid             = valid_q;
  assign result_o.status            = 2'(res_q.status);
  assign result_o.sentence_type     = 2'(res_q.stype);
  assign result_o.computed_checksum = res_q.computed;
  assign result_o.received_checksum = res_q.received;
  assign result_o.line_length       = res_q.line_length;

endmodule

`default_nettype wire
